// ----- sv/assert_macros.svh -----
// assertion helpers, sampled on the block clock and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SDF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define SDF_ASSERT_NEVER(label, cond, msg) \
   `SDF_ASSERT(label, !(cond), msg)

`endif

// ----- sv/sdfbf_pkg.sv -----
package sdfbf_pkg;

   // sizes of the image store and fixed point format
   localparam int MAX_DIM   = 64;
   localparam int FRAC_BITS = 16;
   localparam int DIM_W     = $clog2(MAX_DIM);
   localparam int SW_W      = DIM_W + 1;
   localparam int ADDR_W    = 2 * DIM_W;

   // field and register widths
   localparam int SRC_W      = 7;
   localparam int TGT_W      = 9;
   localparam int BYTE_W     = 8;
   localparam int COORD_W    = 8;
   localparam int DIST_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // datapath widths
   localparam int DVD_W   = TGT_W + FRAC_BITS;
   localparam int DSR_W   = TGT_W;
   localparam int POS_W   = TGT_W + FRAC_BITS + 1;
   localparam int SQ_W    = 2 * POS_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int SCALE_W = 14;
   localparam int ROOT_W  = 15;

   // arithmetic constants
   localparam int SAT_LIMIT = 30000;
   localparam int SCALE     = 10000;
   localparam int SAT_SQ    = SAT_LIMIT * SAT_LIMIT;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_W = 2'd0,
      CSR_SRC_H = 2'd1,
      CSR_TGT_W = 2'd2,
      CSR_TGT_H = 2'd3
   } csr_idx_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      DV_STEP_X = 2'd0,
      DV_STEP_Y = 2'd1,
      DV_REF_X  = 2'd2,
      DV_REF_Y  = 2'd3
   } div_step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_REF_RD,
      ST_REF_CAP,
      ST_SCAN,
      ST_DRAIN,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      RT_IDLE,
      RT_LO,
      RT_HI,
      RT_SUM,
      RT_CHK,
      RT_ITER,
      RT_DONE
   } root_state_type;

   typedef struct packed {
      logic [SRC_W-1:0] src_w;
      logic [SRC_W-1:0] src_h;
      logic [TGT_W-1:0] tgt_w;
      logic [TGT_W-1:0] tgt_h;
   } cfg_type;

   typedef struct packed {
      opcode_type         op;
      logic [BYTE_W-1:0]  pixel;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] out_count;
   } stat_type;

endpackage

// ----- sv/sdfbf_front.sv -----
module sdfbf_front
   import sdfbf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_opcode,
   input  logic [BYTE_W-1:0]  req_pixel_byte,
   input  logic [COORD_W-1:0] req_coord_x,
   input  logic [COORD_W-1:0] req_coord_y,
   output logic               req_full,
   output logic               cmd_valid,
   output cmd_type            cmd,
   input  logic               cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       accept, keep, in_store;
   cmd_type    item;

   // classify: loads outside the store are taken and dropped
   assign accept   = req_push && !req_full;
   assign in_store = ({1'b0, req_coord_x} < (COORD_W+1)'(MAX_DIM)) &&
                     ({1'b0, req_coord_y} < (COORD_W+1)'(MAX_DIM));
   assign keep     = accept && ((opcode_type'(req_opcode) == OP_QUERY) || in_store);
   assign item     = '{op: opcode_type'(req_opcode), pixel: req_pixel_byte,
                       x: req_coord_x, y: req_coord_y};

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // two-beat queue toward the back end
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (keep) wr_ptr_ff <= !wr_ptr_ff;
         if (cmd_pop && cmd_valid) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(keep) - 2'(cmd_pop && cmd_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (keep) q_ff[wr_ptr_ff] <= item;
   end

endmodule

// ----- sv/sdfbf_div.sv -----
module sdfbf_div
   import sdfbf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient,
   output logic [DSR_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] rem_ff, rem_in, dsr_ff;
   logic [DSR_W:0]   trial;
   logic             ge;

   // one restoring step per cycle
   assign trial  = {rem_ff, quo_ff[DVD_W-1]};
   assign ge     = trial >= {1'b0, dsr_ff};
   assign rem_in = ge ? DSR_W'(trial - {1'b0, dsr_ff}) : DSR_W'(trial);
   assign quo_in = {quo_ff[DVD_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- sv/sdfbf_root.sv -----
module sdfbf_root
   import sdfbf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  sum,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int LO_W  = SUM_W / 2;
   localparam int HI_W  = SUM_W - LO_W;
   localparam int PW    = SUM_W + SCALE_W;
   localparam int TW    = PW - 2 * FRAC_BITS;
   localparam int BIT_W = $clog2(ROOT_W);

   root_state_type          state_ff, state_in;
   logic [SUM_W-1:0]        sum_ff;
   logic [LO_W+SCALE_W-1:0] lo_ff;
   logic [HI_W+SCALE_W-1:0] hi_ff;
   logic [TW-1:0]           t_ff;
   logic [ROOT_W-1:0]       root_ff, cand;
   logic [BIT_W-1:0]        bit_ff;
   logic [PW-1:0]           scaled;
   logic                    sat, fits;

   // scaled square: sum * 10000 from two partial products
   assign scaled = PW'(lo_ff) + (PW'(hi_ff) << LO_W);
   assign sat    = t_ff >= TW'(SAT_SQ);
   assign cand   = root_ff | (ROOT_W'(1) << bit_ff);
   assign fits   = (TW'(cand) * TW'(cand)) <= t_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RT_IDLE: if (start) state_in = RT_LO;
         RT_LO:   state_in = RT_HI;
         RT_HI:   state_in = RT_SUM;
         RT_SUM:  state_in = RT_CHK;
         RT_CHK:  state_in = sat ? RT_DONE : RT_ITER;
         RT_ITER: if (bit_ff == '0) state_in = RT_DONE;
         RT_DONE: state_in = RT_IDLE;
         default: state_in = RT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == RT_DONE);
      root = root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= RT_IDLE;
      else       state_ff <= state_in;
   end

   // datapath: bit-by-bit square root of the scaled sum
   always_ff @(posedge clock) begin
      case (state_ff)
         RT_IDLE: sum_ff <= sum;
         RT_LO:   lo_ff  <= sum_ff[LO_W-1:0] * SCALE_W'(SCALE);
         RT_HI:   hi_ff  <= sum_ff[SUM_W-1:LO_W] * SCALE_W'(SCALE);
         RT_SUM:  t_ff   <= scaled[PW-1:2*FRAC_BITS];
         RT_CHK: begin
            root_ff <= sat ? ROOT_W'(SAT_LIMIT) : '0;
            bit_ff  <= BIT_W'(ROOT_W - 1);
         end
         RT_ITER: begin
            if (fits) root_ff <= cand;
            bit_ff <= bit_ff - BIT_W'(1);
         end
         default: ;
      endcase
   end

endmodule

// ----- sv/sdfbf_back.sv -----
module sdfbf_back
   import sdfbf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     cmd_valid,
   input  cmd_type                  cmd,
   output logic                     cmd_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [DIST_W-1:0] rsp_signed_distance,
   output stat_type                 stat
);

   back_state_type state_ff, state_in;
   div_step_type   div_sel_ff;

   logic [SW_W-1:0]    sw_eff, sh_eff;
   logic [TGT_W-1:0]   tw_eff, th_eff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [DVD_W-1:0]   stepx_ff, stepy_ff;
   logic [SW_W-1:0]    remx_ff, remy_ff;
   logic [DIM_W-1:0]   rx_ff, ry_ff;
   logic [BYTE_W-1:0]  ref_ff, rd_data_ff;
   logic [SW_W-1:0]    i_ff, j_ff, pxr_ff, pyr_ff;
   logic [POS_W-1:0]   px_ff, py_ff;

   logic [POS_W-1:0]   ub_ff, vb_ff;
   logic               valid_b_ff, valid_c_ff, diff_c_ff;
   logic [SQ_W-1:0]    uu_ff, vv_ff;
   logic [SUM_W-1:0]   best_ff, s_sum;
   logic               found_ff;
   logic [ROOT_W-1:0]  mag_ff;

   logic [DIST_W-1:0]  oq_ff [2];
   logic               owr_ff, ord_ff;
   logic [1:0]         ocnt_ff;

   logic [BYTE_W-1:0]  mem [MAX_DIM*MAX_DIM];
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_we, div_start, root_start, oq_push, div_done, root_done;
   logic [DVD_W-1:0]   dvd, quo;
   logic [DSR_W-1:0]   dsr, rem;
   logic [ROOT_W-1:0]  root;
   logic [COORD_W+SW_W-1:0] mref;
   logic               last_i, last_j, carry_x, carry_y;
   logic [SW_W:0]      sum_rx, sum_ry;
   logic [POS_W-1:0]   cx, cy, u_mag, v_mag;
   logic [DVD_W-1:0]   ref_lim;
   logic [DIST_W-1:0]  result;

   // effective sizes
   always_comb begin
      if (cfg.src_w == '0)                                  sw_eff = SW_W'(1);
      else if ({1'b0, cfg.src_w} > (SRC_W+1)'(MAX_DIM))     sw_eff = SW_W'(MAX_DIM);
      else                                                  sw_eff = SW_W'(cfg.src_w);
      if (cfg.src_h == '0)                                  sh_eff = SW_W'(1);
      else if ({1'b0, cfg.src_h} > (SRC_W+1)'(MAX_DIM))     sh_eff = SW_W'(MAX_DIM);
      else                                                  sh_eff = SW_W'(cfg.src_h);
      tw_eff = (cfg.tgt_w == '0) ? TGT_W'(1) : cfg.tgt_w;
      th_eff = (cfg.tgt_h == '0) ? TGT_W'(1) : cfg.tgt_h;
   end

   // divider operands for each setup step
   always_comb begin
      mref = '0;
      case (div_sel_ff)
         DV_STEP_X: begin
            dvd = {tw_eff, {FRAC_BITS{1'b0}}};
            dsr = DSR_W'(sw_eff);
         end
         DV_STEP_Y: begin
            dvd = {th_eff, {FRAC_BITS{1'b0}}};
            dsr = DSR_W'(sh_eff);
         end
         DV_REF_X: begin
            mref = x_ff * sw_eff;
            dvd  = DVD_W'(mref);
            dsr  = tw_eff;
         end
         default: begin
            mref = y_ff * sh_eff;
            dvd  = DVD_W'(mref);
            dsr  = th_eff;
         end
      endcase
   end

   sdfbf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dvd),
      .divisor   (dsr),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   sdfbf_root u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .sum   (best_ff),
      .done  (root_done),
      .root  (root)
   );

   // scan position stepping
   assign last_i  = (i_ff == sw_eff - SW_W'(1));
   assign last_j  = (j_ff == sh_eff - SW_W'(1));
   assign sum_rx  = {1'b0, pxr_ff} + {1'b0, remx_ff};
   assign sum_ry  = {1'b0, pyr_ff} + {1'b0, remy_ff};
   assign carry_x = sum_rx >= {1'b0, sw_eff};
   assign carry_y = sum_ry >= {1'b0, sh_eff};
   assign cx      = POS_W'({x_ff, {FRAC_BITS{1'b0}}});
   assign cy      = POS_W'({y_ff, {FRAC_BITS{1'b0}}});
   assign u_mag   = (px_ff >= cx) ? px_ff - cx : cx - px_ff;
   assign v_mag   = (py_ff >= cy) ? py_ff - cy : cy - py_ff;
   assign s_sum   = SUM_W'(uu_ff) + SUM_W'(vv_ff);
   assign ref_lim = (div_sel_ff == DV_REF_X) ? DVD_W'(sw_eff) : DVD_W'(sh_eff);
   assign result  = (ref_ff != '0) ? DIST_W'(mag_ff) : DIST_W'(0) - DIST_W'(mag_ff);
   assign rd_addr = (state_ff == ST_REF_RD) ? {ry_ff, rx_ff}
                                             : {j_ff[DIM_W-1:0], i_ff[DIM_W-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (cmd_valid && cmd.op == OP_QUERY) state_in = ST_DIV_GO;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_done) state_in = (div_sel_ff == DV_REF_Y) ? ST_REF_RD
                                                                        : ST_DIV_GO;
         ST_REF_RD:    state_in = ST_REF_CAP;
         ST_REF_CAP:   state_in = ST_SCAN;
         ST_SCAN:      if (last_i && last_j) state_in = ST_DRAIN;
         ST_DRAIN:     if (!valid_b_ff && !valid_c_ff)
                          state_in = found_ff ? ST_ROOT_GO : ST_EMIT;
         ST_ROOT_GO:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: if (root_done) state_in = ST_EMIT;
         ST_EMIT:      if (ocnt_ff != 2'd2) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cmd_pop    = (state_ff == ST_IDLE) && cmd_valid;
      mem_we     = (state_ff == ST_IDLE) && cmd_valid && (cmd.op == OP_LOAD);
      div_start  = (state_ff == ST_DIV_GO);
      root_start = (state_ff == ST_ROOT_GO);
      oq_push    = (state_ff == ST_EMIT) && (ocnt_ff != 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_sel_ff <= DV_STEP_X;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_b_ff <= (state_ff == ST_SCAN);
         valid_c_ff <= valid_b_ff;
         if (state_ff == ST_IDLE) div_sel_ff <= DV_STEP_X;
         else if (state_ff == ST_DIV_WAIT && div_done)
            div_sel_ff <= div_step_type'(div_sel_ff + 2'd1);
      end
   end

   // image store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[{cmd.y[DIM_W-1:0], cmd.x[DIM_W-1:0]}] <= cmd.pixel;
      rd_data_ff <= mem[rd_addr];
   end

   // query setup and scan sequencing
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_valid) begin
         x_ff <= cmd.x;
         y_ff <= cmd.y;
      end
      if (state_ff == ST_DIV_WAIT && div_done) begin
         case (div_sel_ff)
            DV_STEP_X: begin
               stepx_ff <= quo;
               remx_ff  <= SW_W'(rem);
            end
            DV_STEP_Y: begin
               stepy_ff <= quo;
               remy_ff  <= SW_W'(rem);
            end
            DV_REF_X:  rx_ff <= (quo >= ref_lim) ? DIM_W'(sw_eff - SW_W'(1)) : DIM_W'(quo);
            default:   ry_ff <= (quo >= ref_lim) ? DIM_W'(sh_eff - SW_W'(1)) : DIM_W'(quo);
         endcase
      end
      if (state_ff == ST_REF_CAP) begin
         ref_ff <= rd_data_ff;
         i_ff   <= '0;
         j_ff   <= '0;
         px_ff  <= '0;
         pxr_ff <= '0;
         py_ff  <= '0;
         pyr_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         if (last_i) begin
            i_ff   <= '0;
            px_ff  <= '0;
            pxr_ff <= '0;
            j_ff   <= j_ff + SW_W'(1);
            py_ff  <= py_ff + POS_W'(stepy_ff) + POS_W'(carry_y);
            pyr_ff <= carry_y ? SW_W'(sum_ry - {1'b0, sh_eff}) : SW_W'(sum_ry);
         end else begin
            i_ff   <= i_ff + SW_W'(1);
            px_ff  <= px_ff + POS_W'(stepx_ff) + POS_W'(carry_x);
            pxr_ff <= carry_x ? SW_W'(sum_rx - {1'b0, sw_eff}) : SW_W'(sum_rx);
         end
      end
      if (state_ff == ST_ROOT_WAIT && root_done) mag_ff <= root;
      else if (state_ff == ST_DRAIN)             mag_ff <= ROOT_W'(SAT_LIMIT);
   end

   // distance pipeline: offsets, squares, running minimum
   always_ff @(posedge clock) begin
      ub_ff     <= u_mag;
      vb_ff     <= v_mag;
      uu_ff     <= ub_ff * ub_ff;
      vv_ff     <= vb_ff * vb_ff;
      diff_c_ff <= (rd_data_ff != ref_ff);
      if (state_ff == ST_REF_CAP) found_ff <= 1'b0;
      else if (valid_c_ff && diff_c_ff && (!found_ff || s_sum < best_ff)) begin
         best_ff  <= s_sum;
         found_ff <= 1'b1;
      end
   end

   // two-beat result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= 1'b0;
         ord_ff  <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         if (oq_push) owr_ff <= !owr_ff;
         if (rsp_pop && !rsp_empty) ord_ff <= !ord_ff;
         ocnt_ff <= ocnt_ff + 2'(oq_push) - 2'(rsp_pop && !rsp_empty);
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) oq_ff[owr_ff] <= result;
   end

   assign rsp_empty           = (ocnt_ff == 2'd0);
   assign rsp_signed_distance = $signed(oq_ff[ord_ff]);
   assign stat                = '{busy: (state_ff != ST_IDLE), out_count: ocnt_ff};

endmodule

// ----- sv/signed_distance_field_brute_force_top.sv -----
// Brute-force signed distance field. Loads (opcode 0) write one byte into a 64 x 64 image
// store while the back end is idle; loads outside the store are dropped. A query
// (opcode 1) returns one signed distance in hundredths of an output pixel, positive when
// the reference pixel is nonzero, saturated at 30000. In the back end, four serial
// divisions set up the scale steps and reference pixel, then the scan reads one stored
// pixel per cycle through the single read port of the image store, followed by a drain
// and, if a differing pixel was found, a bit-serial square root. Two-beat queues on the
// request and result sides let loads and queries be pushed while an earlier result waits.
// Pixels read by a query must have been loaded; the user must write configuration only
// while the block is idle, and the block itself does not enforce this.
`include "assert_macros.svh"

module signed_distance_field_brute_force_top
   import sdfbf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     req_opcode,
   input  logic [BYTE_W-1:0]        req_pixel_byte,
   input  logic [COORD_W-1:0]       req_coord_x,
   input  logic [COORD_W-1:0]       req_coord_y,
   output logic                     req_full,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [DIST_W-1:0] rsp_signed_distance,
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data
);

   cfg_type  cfg_ff;
   cmd_type  cmd;
   logic     cmd_valid, cmd_pop;
   stat_type stat;
   logic     dist_ok;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_w <= SRC_W'(64);
         cfg_ff.src_h <= SRC_W'(64);
         cfg_ff.tgt_w <= TGT_W'(64);
         cfg_ff.tgt_h <= TGT_W'(64);
      end else if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SRC_W: cfg_ff.src_w <= csr_write_data[SRC_W-1:0];
            CSR_SRC_H: cfg_ff.src_h <= csr_write_data[SRC_W-1:0];
            CSR_TGT_W: cfg_ff.tgt_w <= csr_write_data[TGT_W-1:0];
            CSR_TGT_H: cfg_ff.tgt_h <= csr_write_data[TGT_W-1:0];
         endcase
      end
   end

   sdfbf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_opcode     (req_opcode),
      .req_pixel_byte (req_pixel_byte),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_full       (req_full),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   sdfbf_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_pop             (cmd_pop),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_signed_distance (rsp_signed_distance),
      .stat                (stat)
   );

   // checks
   assign dist_ok = (rsp_signed_distance >= -SAT_LIMIT) && (rsp_signed_distance <= SAT_LIMIT);

   `SDF_ASSERT(dist_in_range, !rsp_empty |-> dist_ok, "distance out of range")
   `SDF_ASSERT_NEVER(result_without_beat, stat.out_count == 2'd0 && !rsp_empty, "empty queue shown")
   `SDF_ASSERT(result_from_query, $rose(!rsp_empty) |-> $past(stat.busy), "result without a query")

endmodule
